>>> sv/dbhl_pkg.sv
`timescale 1ns / 1ps
// Package for the terrain height lookup: field widths, register indexes,
// item kinds and the control struct passed to the divider.
// No dependencies.
package dbhl_pkg;

	// Field widths
	localparam int LON_W      = 33;
	localparam int LAT_W      = 32;
	localparam int PPD_W      = 28;
	localparam int DIM_W      = 13;
	localparam int LD_ADDR_W  = 21;
	localparam int POST_W     = 16;
	localparam int HEIGHT_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 33;
	// Grid address: row index times stride plus column, up to 4095 * 4096 + 4095
	localparam int GADDR_W    = 25;
	// Post index taken from the product of offset and posts-per-degree
	localparam int IDX_W      = 22;
	// Column or row index inside a legal tile
	localparam int POS_W      = 12;

	// Item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_LON = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_LAT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LON_PPD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAT_PPD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES      = 3'd5;

	// Register reset values
	localparam logic [LON_W-1:0] RST_CORNER_LON = 33'd0;
	localparam logic [LAT_W-1:0] RST_CORNER_LAT = 32'd16777216;
	localparam logic [PPD_W-1:0] RST_PPD        = 28'd78643200;
	localparam logic [DIM_W-1:0] RST_DIM        = 13'd1201;

	// No-data marker and output saturation limits
	localparam logic [POST_W-1:0]   NULL_POST  = 16'h8000;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 24'h7FFFFF;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 24'h800000;

	// Per-item control that rides along with the divider
	typedef struct packed {
		logic ok;
		logic neg;
	} div_ctl_t;

endpackage

>>> sv/dbhl_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the height lookup: item input, result output and
// register write port. Depends on dbhl_pkg.
interface dbhl_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [dbhl_pkg::LD_ADDR_W-1:0]        post_address;
	logic signed [dbhl_pkg::POST_W-1:0]    post_value;
	logic signed [dbhl_pkg::LON_W-1:0]     query_lon;
	logic signed [dbhl_pkg::LAT_W-1:0]     query_lat;
	modport source (output valid, kind, post_address, post_value, query_lon, query_lat,
		input ready);
	modport sink (input valid, kind, post_address, post_value, query_lon, query_lat,
		output ready);
endinterface

interface dbhl_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dbhl_pkg::HEIGHT_W-1:0]  height;
	logic                                  height_valid;
	modport source (output valid, height, height_valid, input ready);
	modport sink (input valid, height, height_valid, output ready);
endinterface

interface dbhl_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [dbhl_pkg::CFG_IDX_W-1:0]        index;
	logic [dbhl_pkg::CFG_DATA_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/dbhl_grid.sv
`timescale 1ns / 1ps
// Elevation grid split into even and odd word banks, each with one write
// port and two registered read ports. Depends on dbhl_pkg.
module dbhl_grid #(
	parameter int GRID_DEPTH = 2097152
) (
	input  logic                               clk,
	input  logic                               rd_en,
	input  logic [dbhl_pkg::GADDR_W-1:0]       rd_base,
	input  logic [dbhl_pkg::GADDR_W-1:0]       rd_below,
	input  logic                               wr_en,
	input  logic [dbhl_pkg::LD_ADDR_W-1:0]     wr_addr,
	input  logic [dbhl_pkg::POST_W-1:0]        wr_data,
	output logic [3:0][dbhl_pkg::POST_W-1:0]   post
);

	localparam int BANK_DEPTH = (GRID_DEPTH + 1) / 2;
	localparam int BIW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int AW         = dbhl_pkg::GADDR_W;

	logic [dbhl_pkg::POST_W-1:0] bank_even [BANK_DEPTH];
	logic [dbhl_pkg::POST_W-1:0] bank_odd  [BANK_DEPTH];

	logic [AW-1:0]  base_inc, below_inc, wa;
	logic [BIW-1:0] ie_top, io_top, ie_bot, io_bot, iw;

	logic [dbhl_pkg::POST_W-1:0] e_top_q, o_top_q, e_bot_q, o_bot_q;
	logic                        swap_top_q, swap_bot_q;

	// Pair at word a: the even bank holds (a+1)/2, the odd bank a/2
	assign base_inc  = rd_base + AW'(1);
	assign below_inc = rd_below + AW'(1);
	assign ie_top    = base_inc[BIW:1];
	assign io_top    = rd_base[BIW:1];
	assign ie_bot    = below_inc[BIW:1];
	assign io_bot    = rd_below[BIW:1];
	assign wa        = AW'(wr_addr);
	assign iw        = wa[BIW:1];

	// Loads
	always_ff @(posedge clk) begin
		if (wr_en && !wa[0]) begin
			bank_even[iw] <= wr_data;
		end
		if (wr_en && wa[0]) begin
			bank_odd[iw] <= wr_data;
		end
	end

	// Four-post fetch
	always_ff @(posedge clk) begin
		if (rd_en) begin
			e_top_q    <= bank_even[ie_top];
			o_top_q    <= bank_odd[io_top];
			e_bot_q    <= bank_even[ie_bot];
			o_bot_q    <= bank_odd[io_bot];
			swap_top_q <= rd_base[0];
			swap_bot_q <= rd_below[0];
		end
	end

	// Back into column order: left post first
	assign post[0] = swap_top_q ? o_top_q : e_top_q;
	assign post[1] = swap_top_q ? e_top_q : o_top_q;
	assign post[2] = swap_bot_q ? o_bot_q : e_bot_q;
	assign post[3] = swap_bot_q ? e_bot_q : o_bot_q;

endmodule

>>> sv/dbhl_div.sv
`timescale 1ns / 1ps
// Pipelined signed divider: weighted sum times 256 over weight sum, one
// quotient bit per stage, then saturation into the result register.
// Depends on dbhl_pkg and dbhl_if.
module dbhl_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [FRAC_BITS+21:0]         in_num,
	input  logic signed [FRAC_BITS+5:0]          in_den,
	input  logic                                 in_ok,
	dbhl_rsp_if.source                           rsp
);

	localparam int NUMW = FRAC_BITS + 22;
	localparam int DENW = FRAC_BITS + 6;
	localparam int MW   = FRAC_BITS + 30;
	localparam int QB   = dbhl_pkg::HEIGHT_W;
	localparam int LAST = QB + 1;

	logic                          v_s   [LAST+1];
	logic                          en_s  [LAST+1];
	logic [MW-1:0]                 rem_s [LAST+1];
	logic [DENW-1:0]               dm_s  [LAST+1];
	logic [QB-1:0]                 q_s   [LAST+1];
	logic                          ovf_s [LAST+1];
	dbhl_pkg::div_ctl_t            ctl_s [LAST+1];

	logic                          en_out;
	logic                          valid_q;
	logic [QB-1:0]                 height_q;
	logic                          hv_q;

	logic [NUMW-1:0]               num_abs;
	logic [DENW-1:0]               den_abs;
	logic [QB-1:0]                 h_c;

	assign en_out   = !valid_q || rsp.ready;
	assign in_ready = en_s[0];

	// Magnitudes for the unsigned divide
	assign num_abs = in_num[NUMW-1] ? NUMW'(-in_num) : NUMW'(in_num);
	assign den_abs = in_den[DENW-1] ? DENW'(-in_den) : DENW'(in_den);

	genvar j;
	generate
		for (j = 0; j <= LAST; j++) begin : g_stage
			if (j == LAST) begin : g_en_last
				assign en_s[j] = !v_s[j] || en_out;
			end else begin : g_en
				assign en_s[j] = !v_s[j] || en_s[j+1];
			end

			if (j == 0) begin : g_v0
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_s[j] <= 1'b0;
					end else if (en_s[j]) begin
						v_s[j] <= in_valid;
					end
				end
			end else begin : g_vn
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_s[j] <= 1'b0;
					end else if (en_s[j]) begin
						v_s[j] <= v_s[j-1];
					end
				end
			end

			if (j == 0) begin : g_abs
				always_ff @(posedge clk) begin
					if (en_s[j]) begin
						rem_s[j]     <= {num_abs, 8'b0};
						dm_s[j]      <= den_abs;
						q_s[j]       <= '0;
						ovf_s[j]     <= 1'b0;
						ctl_s[j].ok  <= in_ok && (in_den != '0);
						ctl_s[j].neg <= in_num[NUMW-1] ^ in_den[DENW-1];
					end
				end
			end else if (j == 1) begin : g_ovf
				// Quotient would need more than QB bits
				always_ff @(posedge clk) begin
					if (en_s[j]) begin
						rem_s[j] <= rem_s[j-1];
						dm_s[j]  <= dm_s[j-1];
						q_s[j]   <= '0;
						ovf_s[j] <= rem_s[j-1] >= {dm_s[j-1], {QB{1'b0}}};
						ctl_s[j] <= ctl_s[j-1];
					end
				end
			end else begin : g_bit
				localparam int K = LAST - j;
				logic [MW-1:0] trial;
				logic          ge;
				assign trial = MW'(dm_s[j-1]) << K;
				assign ge    = rem_s[j-1] >= trial;
				always_ff @(posedge clk) begin
					if (en_s[j]) begin
						rem_s[j] <= ge ? (rem_s[j-1] - trial) : rem_s[j-1];
						dm_s[j]  <= dm_s[j-1];
						q_s[j]   <= q_s[j-1] | (ge ? (QB'(1) << K) : '0);
						ovf_s[j] <= ovf_s[j-1];
						ctl_s[j] <= ctl_s[j-1];
					end
				end
			end
		end
	endgenerate

	// Sign and saturation
	always_comb begin
		if (!ctl_s[LAST].neg) begin
			h_c = (ovf_s[LAST] || q_s[LAST][QB-1]) ? dbhl_pkg::HEIGHT_MAX : q_s[LAST];
		end else begin
			h_c = (ovf_s[LAST] || (q_s[LAST] > dbhl_pkg::HEIGHT_MIN)) ?
				dbhl_pkg::HEIGHT_MIN : QB'(-q_s[LAST]);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_out) begin
			valid_q <= v_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			height_q <= ctl_s[LAST].ok ? h_c : '0;
			hv_q     <= ctl_s[LAST].ok;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.height       = height_q;
	assign rsp.height_valid = hv_q;

	// Checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.height_valid |-> rsp.height == '0)
		else $error("invalid result with nonzero height");

	a_entry_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s[0])
		else $error("divider refuses with an empty entry stage");

endmodule

>>> sv/dem_bilinear_height_lookup.sv
`timescale 1ns / 1ps
// Terrain height lookup top level. One query or post load per clock cycle
// while the result channel is not stalled; a query passes nine stages of
// coordinate, weight and fetch logic, then the divider. The grid is two
// word-parity banks with two read ports each, so all four posts of a query
// arrive in the same cycle. Loads travel the pipeline and write when they
// reach the fetch stage, keeping order with queries. The grid has no
// clearing pass; posts must be loaded before they are read. The user must
// write registers only while no transaction is in flight; the block does
// not enforce this. Depends on dbhl_pkg, dbhl_if, dbhl_grid and dbhl_div.
module dem_bilinear_height_lookup #(
	parameter int GRID_DEPTH = 2097152,
	parameter int FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	dbhl_req_if.sink   req,
	dbhl_rsp_if.source rsp,
	dbhl_cfg_if.sink   cfg
);

	localparam int F     = FRAC_BITS;
	localparam int SHR   = 40 - F;
	localparam int WW    = F + 4;
	localparam int PW    = dbhl_pkg::POST_W + WW;
	localparam int NUMW  = PW + 2;
	localparam int DENW  = WW + 2;
	localparam int AW    = dbhl_pkg::GADDR_W;
	localparam int XW    = dbhl_pkg::IDX_W;
	localparam int PSW   = dbhl_pkg::POS_W;
	localparam int DW    = dbhl_pkg::DIM_W;
	localparam logic [F+1:0]  ONE_FX = (F+2)'(1) << F;
	localparam logic [AW-1:0] GD_A   = AW'(GRID_DEPTH);
	localparam logic [AW-1:0] GD_M1  = AW'(GRID_DEPTH - 1);

	// Registers
	logic [dbhl_pkg::LON_W-1:0] corner_lon_q;
	logic [dbhl_pkg::LAT_W-1:0] corner_lat_q;
	logic [dbhl_pkg::PPD_W-1:0] lon_ppd_q, lat_ppd_q;
	logic [DW-1:0]              samples_q, lines_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_lon_q <= dbhl_pkg::RST_CORNER_LON;
			corner_lat_q <= dbhl_pkg::RST_CORNER_LAT;
			lon_ppd_q    <= dbhl_pkg::RST_PPD;
			lat_ppd_q    <= dbhl_pkg::RST_PPD;
			samples_q    <= dbhl_pkg::RST_DIM;
			lines_q      <= dbhl_pkg::RST_DIM;
		end else if (cfg.valid) begin
			case (cfg.index)
				dbhl_pkg::CFG_CORNER_LON: corner_lon_q <= cfg.data[dbhl_pkg::LON_W-1:0];
				dbhl_pkg::CFG_CORNER_LAT: corner_lat_q <= cfg.data[dbhl_pkg::LAT_W-1:0];
				dbhl_pkg::CFG_LON_PPD:    lon_ppd_q    <= cfg.data[dbhl_pkg::PPD_W-1:0];
				dbhl_pkg::CFG_LAT_PPD:    lat_ppd_q    <= cfg.data[dbhl_pkg::PPD_W-1:0];
				dbhl_pkg::CFG_SAMPLES:    samples_q    <= cfg.data[DW-1:0];
				dbhl_pkg::CFG_LINES:      lines_q      <= cfg.data[DW-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic div_ready;

	assign en_s9 = !v_s9 || div_ready;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// Kind and load payload ride through stage 6
	logic                                kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic [dbhl_pkg::LD_ADDR_W-1:0]      ldad_s1, ldad_s2, ldad_s3, ldad_s4, ldad_s5, ldad_s6;
	logic [dbhl_pkg::POST_W-1:0]         ldvl_s1, ldvl_s2, ldvl_s3, ldvl_s4, ldvl_s5, ldvl_s6;

	// Stage 1: offsets from the corner
	logic [dbhl_pkg::LON_W:0] dlon_s1;
	logic [dbhl_pkg::LAT_W:0] dlat_s1;

	// Stage 2: partial products
	logic signed [16:0] lon_hi;
	logic signed [15:0] lat_hi;
	logic signed [28:0] lon_ppd_sx, lat_ppd_sx;
	logic [44:0]        pplo_lon_s2, pplo_lat_s2;
	logic signed [45:0] pphi_lon_s2;
	logic signed [44:0] pphi_lat_s2;

	assign lon_hi     = $signed(dlon_s1[33:17]);
	assign lat_hi     = $signed(dlat_s1[32:17]);
	assign lon_ppd_sx = $signed({1'b0, lon_ppd_q});
	assign lat_ppd_sx = $signed({1'b0, lat_ppd_q});

	// Stage 3: full products
	logic [62:0] px_s3;
	logic [61:0] py_s3;

	// Stage 4: post index, edge step back, fractions
	logic [XW-1:0]     x0_raw, y0_raw, x0_st, y0_st;
	logic [DW-1:0]     nsm1, nsm2, nlm1, nlm2;
	logic              step_x, step_y, out_x, out_y, tiny, ok_c;
	logic [F+1:0]      xt0_c, yt0_c;
	logic              ok_s4;
	logic [PSW-1:0]    x0_s4, y0_s4;
	logic signed [F+1:0] xt0_s4, xt1_s4, yt0_s4, yt1_s4;

	assign x0_raw = px_s3[61:40];
	assign y0_raw = py_s3[61:40];
	assign nsm1   = samples_q - DW'(1);
	assign nsm2   = samples_q - DW'(2);
	assign nlm1   = lines_q - DW'(1);
	assign nlm2   = lines_q - DW'(2);
	assign step_x = x0_raw == XW'(nsm1);
	assign step_y = y0_raw == XW'(nlm1);
	assign x0_st  = x0_raw - XW'(step_x);
	assign y0_st  = y0_raw - XW'(step_y);
	assign out_x  = x0_st > XW'(nsm2);
	assign out_y  = y0_st > XW'(nlm2);
	assign tiny   = (samples_q < DW'(2)) || (lines_q < DW'(2));
	assign ok_c   = !px_s3[62] && !py_s3[61] && !tiny && !out_x && !out_y;
	assign xt0_c  = {1'b0, step_x, px_s3[SHR +: F]};
	assign yt0_c  = {1'b0, step_y, py_s3[SHR +: F]};

	// Stage 5: weights and row address
	logic signed [2*F+3:0] m_c [4];
	logic                  ok_s5;
	logic [PSW-1:0]        x0_s5;
	logic [AW-1:0]         row_s5;
	logic signed [WW-1:0]  w_s5 [4];

	assign m_c[0] = xt1_s4 * yt1_s4;
	assign m_c[1] = xt0_s4 * yt1_s4;
	assign m_c[2] = xt1_s4 * yt0_s4;
	assign m_c[3] = xt0_s4 * yt0_s4;

	// Stage 6: post addresses, grid access
	logic                  ok_s6;
	logic [AW-1:0]         base_s6, below_s6;
	logic signed [WW-1:0]  w_s6 [4];
	logic [3:0]            in_c;
	logic                  grid_rd_en, grid_wr_en;
	logic [3:0][dbhl_pkg::POST_W-1:0] grid_post;

	assign in_c[0]    = base_s6 < GD_A;
	assign in_c[1]    = base_s6 < GD_M1;
	assign in_c[2]    = below_s6 < GD_A;
	assign in_c[3]    = below_s6 < GD_M1;
	assign grid_rd_en = en_s7 && v_s6 && (kind_s6 == dbhl_pkg::KIND_QUERY);
	assign grid_wr_en = en_s7 && v_s6 && (kind_s6 == dbhl_pkg::KIND_LOAD) &&
		(AW'(ldad_s6) < GD_A);

	dbhl_grid #(
		.GRID_DEPTH (GRID_DEPTH)
	) u_grid (
		.clk      (clk),
		.rd_en    (grid_rd_en),
		.rd_base  (base_s6),
		.rd_below (below_s6),
		.wr_en    (grid_wr_en),
		.wr_addr  (ldad_s6),
		.wr_data  (ldvl_s6),
		.post     (grid_post)
	);

	// Stage 7: posts arrive, no-data and out-of-grid posts lose their weight
	logic                  ok_s7;
	logic [3:0]            in_s7;
	logic signed [WW-1:0]  w_s7 [4];
	logic signed [WW-1:0]  wm_c [4];
	logic signed [PW-1:0]  prod_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			wm_c[k]   = (!in_s7[k] || (grid_post[k] == dbhl_pkg::NULL_POST)) ?
				'0 : w_s7[k];
			prod_c[k] = $signed(grid_post[k]) * wm_c[k];
		end
	end

	// Stage 8: products; stage 9: sums
	logic                  ok_s8, ok_s9;
	logic signed [PW-1:0]  prod_s8 [4];
	logic signed [WW-1:0]  wm_s8 [4];
	logic signed [NUMW-1:0] num_s9;
	logic signed [DENW-1:0] den_s9;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			// Loads end at the grid
			if (en_s7) v_s7 <= v_s6 && (kind_s6 == dbhl_pkg::KIND_QUERY);
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= req.kind;
			ldad_s1 <= req.post_address;
			ldvl_s1 <= req.post_value;
			dlon_s1 <= {req.query_lon[dbhl_pkg::LON_W-1], req.query_lon} -
				{corner_lon_q[dbhl_pkg::LON_W-1], corner_lon_q};
			dlat_s1 <= {corner_lat_q[dbhl_pkg::LAT_W-1], corner_lat_q} -
				{req.query_lat[dbhl_pkg::LAT_W-1], req.query_lat};
		end
		if (en_s2) begin
			kind_s2     <= kind_s1;
			ldad_s2     <= ldad_s1;
			ldvl_s2     <= ldvl_s1;
			pplo_lon_s2 <= dlon_s1[16:0] * lon_ppd_q;
			pplo_lat_s2 <= dlat_s1[16:0] * lat_ppd_q;
			pphi_lon_s2 <= lon_hi * lon_ppd_sx;
			pphi_lat_s2 <= lat_hi * lat_ppd_sx;
		end
		if (en_s3) begin
			kind_s3 <= kind_s2;
			ldad_s3 <= ldad_s2;
			ldvl_s3 <= ldvl_s2;
			px_s3   <= {pphi_lon_s2, 17'b0} + {18'b0, pplo_lon_s2};
			py_s3   <= {pphi_lat_s2, 17'b0} + {17'b0, pplo_lat_s2};
		end
		if (en_s4) begin
			kind_s4 <= kind_s3;
			ldad_s4 <= ldad_s3;
			ldvl_s4 <= ldvl_s3;
			ok_s4   <= ok_c;
			x0_s4   <= x0_st[PSW-1:0];
			y0_s4   <= y0_st[PSW-1:0];
			xt0_s4  <= $signed(xt0_c);
			yt0_s4  <= $signed(yt0_c);
			xt1_s4  <= $signed(ONE_FX - xt0_c);
			yt1_s4  <= $signed(ONE_FX - yt0_c);
		end
		if (en_s5) begin
			kind_s5 <= kind_s4;
			ldad_s5 <= ldad_s4;
			ldvl_s5 <= ldvl_s4;
			ok_s5   <= ok_s4;
			x0_s5   <= x0_s4;
			row_s5  <= AW'(y0_s4) * AW'(samples_q);
			for (int k = 0; k < 4; k++) begin
				w_s5[k] <= m_c[k][2*F+3:F];
			end
		end
		if (en_s6) begin
			kind_s6  <= kind_s5;
			ldad_s6  <= ldad_s5;
			ldvl_s6  <= ldvl_s5;
			ok_s6    <= ok_s5;
			base_s6  <= row_s5 + AW'(x0_s5);
			below_s6 <= row_s5 + AW'(samples_q) + AW'(x0_s5);
			w_s6     <= w_s5;
		end
		if (en_s7) begin
			ok_s7 <= ok_s6;
			in_s7 <= in_c;
			w_s7  <= w_s6;
		end
		if (en_s8) begin
			ok_s8   <= ok_s7;
			prod_s8 <= prod_c;
			wm_s8   <= wm_c;
		end
		if (en_s9) begin
			ok_s9  <= ok_s8;
			num_s9 <= NUMW'(prod_s8[0]) + NUMW'(prod_s8[1]) +
				NUMW'(prod_s8[2]) + NUMW'(prod_s8[3]);
			den_s9 <= DENW'(wm_s8[0]) + DENW'(wm_s8[1]) +
				DENW'(wm_s8[2]) + DENW'(wm_s8[3]);
		end
	end

	// Normalize by the weight sum
	dbhl_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_ready (div_ready),
		.in_num   (num_s9),
		.in_den   (den_s9),
		.in_ok    (ok_s9),
		.rsp      (rsp)
	);

	// Checks
	a_grid_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(grid_rd_en && grid_wr_en))
		else $error("grid read and write in the same cycle");

	a_s9_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && !div_ready |=> v_s9)
		else $error("stage 9 item lost while the divider stalls");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> v_s1)
		else $error("input refused with stage 1 empty");

endmodule

>>> bench/dem_bilinear_height_lookup_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the terrain height lookup: directed table, then tile
// loads and query streams under several register settings, predicted in-bench or hand-typed.
// Depends on dbhl_pkg, dbhl_if and the dem_bilinear_height_lookup RTL.
module dem_bilinear_height_lookup_test;

	localparam longint GRID_WORDS  = 2097152;
	localparam int     FRAC        = 16;
	localparam longint ONE_FX      = 64'd1 << FRAC;
	localparam longint NO_DATA     = -32768;
	localparam int     CYCLE_LIMIT = 1500000;
	localparam int     SETTLE      = 45;
	// Keeps window queries clear of the unloaded column or row before the window
	localparam longint WIN_MARGIN  = 32;

	typedef struct {
		logic                                kind;
		logic [dbhl_pkg::LD_ADDR_W-1:0]      post_address;
		logic signed [dbhl_pkg::POST_W-1:0]  post_value;
		logic signed [dbhl_pkg::LON_W-1:0]   query_lon;
		logic signed [dbhl_pkg::LAT_W-1:0]   query_lat;
	} lookup_item_t;

	typedef struct {
		logic signed [dbhl_pkg::HEIGHT_W-1:0] height;
		logic                                 height_valid;
	} height_t;

	// Directed row: item plus an optional hand-typed expected height
	typedef struct {
		lookup_item_t item;
		bit           typed;
		height_t      want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;

	dbhl_req_if req_ch();
	dbhl_rsp_if rsp_ch();
	dbhl_cfg_if cfg_ch();

	dem_bilinear_height_lookup i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Register copy and grid contents as the bench believes them
	logic signed [dbhl_pkg::LON_W-1:0] m_corner_lon;
	logic signed [dbhl_pkg::LAT_W-1:0] m_corner_lat;
	logic [dbhl_pkg::PPD_W-1:0]        m_lon_ppd;
	logic [dbhl_pkg::PPD_W-1:0]        m_lat_ppd;
	logic [dbhl_pkg::DIM_W-1:0]        m_samples;
	logic [dbhl_pkg::DIM_W-1:0]        m_lines;
	shortint                           grid_model [longint];

	height_t height_q [$];

	int burst_left;
	logic [7:0] ready_pattern;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		errors++;
	endtask

	function automatic longint read_grid(input longint addr);
		if (addr < 0 || addr >= GRID_WORDS)
			return NO_DATA;
		if (grid_model.exists(addr))
			return longint'(grid_model[addr]);
		return 0;
	endfunction

	// Height predictor: returns 1 when the item yields a result
	function automatic bit predict_height(input lookup_item_t it, output height_t res);
		longint ns, nl, dlon, dlat, px, py, xi, yi, x0, y0;
		longint xt0, yt0, xt1, yt1, base, num, den, hh;
		longint w[4];
		longint p[4];
		bit ok;
		res.height = '0;
		res.height_valid = 1'b0;
		if (it.kind == dbhl_pkg::KIND_LOAD) begin
			grid_model[longint'(it.post_address)] = shortint'(it.post_value);
			return 1'b0;
		end
		ns = longint'(m_samples);
		nl = longint'(m_lines);
		dlon = longint'(it.query_lon) - longint'(m_corner_lon);
		dlat = longint'(m_corner_lat) - longint'(it.query_lat);
		px = dlon * longint'(m_lon_ppd);
		py = dlat * longint'(m_lat_ppd);
		ok = !(px < 0 || py < 0 || ns < 2 || nl < 2);
		if (ok) begin
			xi = px >>> (40 - FRAC);
			yi = py >>> (40 - FRAC);
			x0 = xi >>> FRAC;
			y0 = yi >>> FRAC;
			// last column or row steps back one post
			if (x0 == ns - 1) x0--;
			if (y0 == nl - 1) y0--;
			if (x0 > ns - 2 || y0 > nl - 2)
				ok = 1'b0;
		end
		if (!ok)
			return 1'b1;
		xt0 = xi - x0 * ONE_FX;
		yt0 = yi - y0 * ONE_FX;
		xt1 = ONE_FX - xt0;
		yt1 = ONE_FX - yt0;
		w[0] = (xt1 * yt1) >>> FRAC;
		w[1] = (xt0 * yt1) >>> FRAC;
		w[2] = (xt1 * yt0) >>> FRAC;
		w[3] = (xt0 * yt0) >>> FRAC;
		base = y0 * ns + x0;
		p[0] = read_grid(base);
		p[1] = read_grid(base + 1);
		p[2] = read_grid(base + ns);
		p[3] = read_grid(base + ns + 1);
		num = 0;
		den = 0;
		for (int k = 0; k < 4; k++) begin
			if (p[k] == NO_DATA) w[k] = 0;
			num += p[k] * w[k];
			den += w[k];
		end
		if (den == 0)
			return 1'b1;
		hh = (num * 256) / den;
		if (hh > 8388607) hh = 8388607;
		if (hh < -8388608) hh = -8388608;
		res.height = hh[dbhl_pkg::HEIGHT_W-1:0];
		res.height_valid = 1'b1;
		return 1'b1;
	endfunction

	// Result checker and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		height_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_pattern <= 8'hFF;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (height_q.size() == 0) begin
					report("unexpected result, height", rsp_ch.height, 0);
				end else begin
					want = height_q.pop_front();
					if (rsp_ch.height_valid !== want.height_valid)
						report("height_valid", rsp_ch.height_valid, want.height_valid);
					if (rsp_ch.height !== want.height)
						report("height", rsp_ch.height, want.height);
				end
			end
			if (cycles % 256 == 0)
				ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
			rsp_ch.ready <= ready_pattern[cycles % 8];
		end
	end

	// Drive one item; returns once the transaction is accepted
	task automatic send_item(input lookup_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= it.kind;
		req_ch.post_address <= it.post_address;
		req_ch.post_value   <= it.post_value;
		req_ch.query_lon    <= it.query_lon;
		req_ch.query_lat    <= it.query_lat;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic send_predicted(input lookup_item_t it);
		height_t res;
		send_item(it);
		if (predict_height(it, res))
			height_q.push_back(res);
	endtask

	// Hold the sender until every result is in and the pipeline has emptied
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dbhl_pkg::CFG_IDX_W-1:0] idx, input longint value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[dbhl_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			dbhl_pkg::CFG_CORNER_LON: m_corner_lon = value[dbhl_pkg::LON_W-1:0];
			dbhl_pkg::CFG_CORNER_LAT: m_corner_lat = value[dbhl_pkg::LAT_W-1:0];
			dbhl_pkg::CFG_LON_PPD:    m_lon_ppd    = value[dbhl_pkg::PPD_W-1:0];
			dbhl_pkg::CFG_LAT_PPD:    m_lat_ppd    = value[dbhl_pkg::PPD_W-1:0];
			dbhl_pkg::CFG_SAMPLES:    m_samples    = value[dbhl_pkg::DIM_W-1:0];
			default:                  m_lines      = value[dbhl_pkg::DIM_W-1:0];
		endcase
	endtask

	task automatic set_tile(input longint lon, input longint lat, input longint lon_ppd,
		input longint lat_ppd, input longint ns, input longint nl);
		write_reg(dbhl_pkg::CFG_CORNER_LON, lon);
		write_reg(dbhl_pkg::CFG_CORNER_LAT, lat);
		write_reg(dbhl_pkg::CFG_LON_PPD, lon_ppd);
		write_reg(dbhl_pkg::CFG_LAT_PPD, lat_ppd);
		write_reg(dbhl_pkg::CFG_SAMPLES, ns);
		write_reg(dbhl_pkg::CFG_LINES, nl);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic lookup_item_t make_load(input longint addr, input bit nulls);
		lookup_item_t it;
		int r;
		it.kind = dbhl_pkg::KIND_LOAD;
		it.post_address = addr[dbhl_pkg::LD_ADDR_W-1:0];
		r = $urandom_range(0, 19);
		if (nulls && r < 3)
			it.post_value = dbhl_pkg::NULL_POST;
		else if (r == 3)
			it.post_value = 16'sh7FFF;
		else if (r == 4)
			it.post_value = -16'sh7FFF;
		else
			it.post_value = 16'($urandom);
		it.query_lon = 33'({$urandom, $urandom});
		it.query_lat = 32'($urandom);
		return it;
	endfunction

	// Query aimed at a point of the loaded window, which runs from (x_lo, y_lo)
	// to the far corner of the tile, far edges and just past them; or anywhere with noise
	function automatic lookup_item_t make_query(input bit noise, input longint x_lo,
		input longint y_lo);
		lookup_item_t it;
		longint x, y, lon, lat, xm, ym;
		it.kind = dbhl_pkg::KIND_QUERY;
		it.post_address = 21'($urandom);
		it.post_value = 16'($urandom);
		if (noise) begin
			it.query_lon = 33'({$urandom, $urandom});
			it.query_lat = 32'($urandom);
			return it;
		end
		xm = x_lo * ONE_FX + ((x_lo > 0) ? WIN_MARGIN : 0);
		ym = y_lo * ONE_FX + ((y_lo > 0) ? WIN_MARGIN : 0);
		case ($urandom_range(0, 5))
			0: x = (longint'(m_samples) - 1) * ONE_FX + $urandom_range(0, 2 * ONE_FX);
			1: x = xm + $urandom_range(0, 3);
			default: x = xm + $urandom_range(0, 32'(longint'(m_samples) * ONE_FX - 1 - xm));
		endcase
		case ($urandom_range(0, 5))
			0: y = (longint'(m_lines) - 1) * ONE_FX + $urandom_range(0, 2 * ONE_FX);
			1: y = ym + $urandom_range(0, 3);
			default: y = ym + $urandom_range(0, 32'(longint'(m_lines) * ONE_FX - 1 - ym));
		endcase
		lon = longint'(m_corner_lon) + ((x << 24) + longint'(m_lon_ppd) - 1) / longint'(m_lon_ppd);
		lat = longint'(m_corner_lat) - ((y << 24) + longint'(m_lat_ppd) - 1) / longint'(m_lat_ppd);
		lon += longint'($urandom_range(0, 2)) - 1;
		it.query_lon = lon[dbhl_pkg::LON_W-1:0];
		it.query_lat = lat[dbhl_pkg::LAT_W-1:0];
		return it;
	endfunction

	// One setting: load the window of the tile, then a mix of queries and reloads
	task automatic run_phase(input int n_items, input longint x_lo, input longint y_lo);
		longint ns, nl;
		lookup_item_t it;
		int r;
		ns = longint'(m_samples);
		nl = longint'(m_lines);
		for (longint y = y_lo; y < nl; y++)
			for (longint x = x_lo; x < ns; x++)
				send_predicted(make_load(y * ns + x, 1'b1));
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				drain();
			r = $urandom_range(0, 9);
			if (r == 0)
				it = make_load((y_lo + $urandom_range(0, 32'(nl - 1 - y_lo))) * ns +
					x_lo + $urandom_range(0, 32'(ns - 1 - x_lo)), 1'b1);
			else if (r == 1)
				it = make_load($urandom, 1'b0);
			else
				it = make_query(r == 2, x_lo, y_lo);
			send_predicted(it);
		end
		drain();
	endtask

	directed_row_t rows [$];

	function automatic directed_row_t drow(input logic kind, input longint addr,
		input longint value, input longint lon, input longint lat, input bit typed,
		input longint want_h, input logic want_v);
		directed_row_t d;
		d.item.kind = kind;
		d.item.post_address = addr[dbhl_pkg::LD_ADDR_W-1:0];
		d.item.post_value = value[dbhl_pkg::POST_W-1:0];
		d.item.query_lon = lon[dbhl_pkg::LON_W-1:0];
		d.item.query_lat = lat[dbhl_pkg::LAT_W-1:0];
		d.typed = typed;
		d.want.height = want_h[dbhl_pkg::HEIGHT_W-1:0];
		d.want.height_valid = want_v;
		return d;
	endfunction

	initial begin
		height_t res;
		longint deg;
		arst_n = 1'b0;
		cycles = 0;
		errors = 0;
		burst_left = 0;
		req_ch.valid = 1'b0;
		req_ch.kind = dbhl_pkg::KIND_LOAD;
		req_ch.post_address = '0;
		req_ch.post_value = '0;
		req_ch.query_lon = '0;
		req_ch.query_lat = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = dbhl_pkg::CFG_CORNER_LON;
		cfg_ch.data = '0;
		m_corner_lon = dbhl_pkg::RST_CORNER_LON;
		m_corner_lat = dbhl_pkg::RST_CORNER_LAT;
		m_lon_ppd = dbhl_pkg::RST_PPD;
		m_lat_ppd = dbhl_pkg::RST_PPD;
		m_samples = dbhl_pkg::RST_DIM;
		m_lines = dbhl_pkg::RST_DIM;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: corner cell posts, then edges and no-data
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 0, 100, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1, 200, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1201, 300, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1202, 400, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 0, 16777216, 1, 25600, 1'b1));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, -1, 16777216, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 0, 16777217, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 64'sd3019898880, 0, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, -64'sd3019898880, 0, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 0, -1509949440, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 0, 1509949440, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 6990, 16777216 - 6990, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 0, -32768, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 0, 16777216, 1, 0, 1'b0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 6990, 16777216, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1, 32767, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1201, -32767, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 6990, 16777216 - 6990, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_QUERY, 0, 0, 13000, 16777216 - 13000, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 2097151, 32767, 0, 0, 0, 0, 0));
		rows.push_back(drow(dbhl_pkg::KIND_LOAD, 1048576, -1, 0, 0, 0, 0, 0));
		foreach (rows[i]) begin
			send_item(rows[i].item);
			if (predict_height(rows[i].item, res))
				height_q.push_back(rows[i].typed ? rows[i].want : res);
		end
		drain();

		// Extreme settings: smallest tile, widest row, tallest column
		set_tile(-64'sd3019898880, 64'sd1509949440, 65536, 65536, 2, 2);
		run_phase(120, 0, 0);
		set_tile(-64'sd3019898880, 64'sd1509949440, 235929600, 235929600, 4096, 2);
		run_phase(150, 4088, 0);
		set_tile(64'sd3019898880, -64'sd1509949440, 65536, 235929600, 2, 4096);
		run_phase(120, 0, 4088);

		// Random small tiles
		repeat (7) begin
			deg = longint'($urandom_range(0, 340)) - 170;
			set_tile(deg * 16777216 + $urandom_range(0, 16777215),
				(longint'($urandom_range(0, 160)) - 80) * 16777216 + $urandom_range(0, 16777215),
				$urandom_range(65536, 235929600), $urandom_range(65536, 235929600),
				$urandom_range(2, 10), $urandom_range(2, 10));
			run_phase(150, 0, 0);
		end

		if (errors == 0 && height_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
